@@ src/lhbp_pkg.sv @@
// Shared constants for the local history branch predictor.
// Used by the top level and by its port checker; depends on nothing.

package lhbp_pkg;

	// Default sizes of the predictor tables.
	localparam int PatternIndexBitsDef = 12;
	localparam int HistoryBitsDef      = 12;
	localparam int HistoryIndexBitsDef = 6;
	localparam int CounterBitsDef      = 2;

	// Stream payload widths: branch address (32) plus outcome (1), padded to bytes.
	localparam int AddrW  = 32;
	localparam int SDataW = 40;
	localparam int MDataW = 8;

endpackage

@@ src/lhbp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents. No dependencies.

module lhbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/local_history_branch_predictor.sv @@
// Top level of the two-level local history branch predictor.
// Depends on lhbp_pkg and on lhbp_ram for the history and counter tables.
//
// Usage: each input item on the s_ group is one resolved conditional branch, its
// address and its actual direction. Each item yields exactly one output item on the
// m_ group carrying the prediction the tables gave before this branch updated them.
// The low address bits pick a local history; that history XORed with the address
// picks a saturating counter, and the prediction is "taken" when the counter is in the
// upper half of its range. The counter then steps toward the outcome and the outcome
// shifts into the history.
//
// Throughput is one item per cycle while the receiver takes results and no reset sweep
// runs. An item is registered into stage 1 with its history RAM read, into stage 2 with
// its counter RAM read (both RAMs have registered reads), then into the output register.
// Back-to-back branches that hit the same history or counter entry are covered by
// forwarding the value just written.
//
// After reset the block sweeps both tables, one entry per cycle, for
// 2**max(PATTERN_INDEX_BITS, HISTORY_INDEX_BITS) entries (4096 with the defaults);
// s_tready stays low during that sweep. When the receiver stalls, the whole pipeline
// holds and s_tready drops in the same cycle, so no item is lost or repeated.

module local_history_branch_predictor #(
	parameter int PATTERN_INDEX_BITS = lhbp_pkg::PatternIndexBitsDef,
	parameter int HISTORY_BITS       = lhbp_pkg::HistoryBitsDef,
	parameter int HISTORY_INDEX_BITS = lhbp_pkg::HistoryIndexBitsDef,
	parameter int COUNTER_BITS       = lhbp_pkg::CounterBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lhbp_pkg::SDataW-1:0] s_tdata,  // [31:0] branch_address, [32] taken
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lhbp_pkg::MDataW-1:0] m_tdata   // [0] predicted_taken
);

	import lhbp_pkg::*;

	localparam int PIB      = PATTERN_INDEX_BITS;
	localparam int HIB      = HISTORY_INDEX_BITS;
	localparam int HB       = HISTORY_BITS;
	localparam int CB       = COUNTER_BITS;
	localparam int PatDepth = 1 << PIB;
	localparam int HisDepth = 1 << HIB;
	localparam int MaxIdx   = (PIB > HIB) ? PIB : HIB;

	// Weakly not taken, and the saturation limit.
	localparam logic [CB-1:0] CtrHalf = CB'((1 << CB) / 2 - 1);
	localparam logic [CB-1:0] CtrMax  = CB'((1 << CB) - 1);

	// Table sweep after reset; the top bit of the counter marks it as done.
	logic [MaxIdx:0] clr_q;
	logic            clearing;

	// The pipeline moves as one whenever the output register can take a new value.
	logic adv;
	logic accept;

	// Stage 1: item registered, history RAM data arriving.
	logic           valid_s1;
	logic [PIB-1:0] addr_s1;
	logic [HIB-1:0] hidx_s1;
	logic           taken_s1;
	logic [HB-1:0]  hist_rd;
	logic [HB-1:0]  hist_cur;
	logic [HB-1:0]  hist_next;
	logic [PIB-1:0] pidx;

	// Stage 2: counter RAM data arriving; holds the history just written.
	logic           valid_s2;
	logic [HIB-1:0] hidx_s2;
	logic [HB-1:0]  hist_s2;
	logic [PIB-1:0] pidx_s2;
	logic           taken_s2;
	logic [CB-1:0]  ctr_rd;
	logic [CB-1:0]  ctr_cur;
	logic [CB-1:0]  ctr_next;
	logic           pred;

	// Stage 3: output register; holds the counter just written.
	logic           valid_s3;
	logic           pred_s3;
	logic [PIB-1:0] pidx_s3;
	logic [CB-1:0]  ctr_s3;

	// Table write ports.
	logic           hist_we;
	logic [HIB-1:0] hist_waddr;
	logic [HB-1:0]  hist_wdata;
	logic           pat_we;
	logic [PIB-1:0] pat_waddr;
	logic [CB-1:0]  pat_wdata;

	assign clearing = !clr_q[MaxIdx];
	assign adv      = !valid_s3 || m_tready;
	assign s_tready = adv && !clearing;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Stage 1 logic. If the previous item wrote the same history entry on the edge
	// this item's read was issued, the RAM returned the stale value; use stage 2's copy.
	assign hist_cur  = (valid_s2 && hidx_s2 == hidx_s1) ? hist_s2 : hist_rd;
	assign pidx      = addr_s1 ^ PIB'(hist_cur);
	assign hist_next = HB'({hist_cur, taken_s1});

	// Stage 2 logic, with the same forwarding for the counter written on the edge its read was issued.
	assign ctr_cur = (valid_s3 && pidx_s3 == pidx_s2) ? ctr_s3 : ctr_rd;
	assign pred    = ctr_cur > CtrHalf;

	always_comb begin
		ctr_next = ctr_cur;
		if (taken_s2) begin
			if (ctr_cur != CtrMax) begin
				ctr_next = ctr_cur + 1'b1;
			end
		end else begin
			if (ctr_cur != '0) begin
				ctr_next = ctr_cur - 1'b1;
			end
		end
	end

	// Write ports: the reset sweep owns them until it finishes.
	assign hist_we    = clearing || (adv && valid_s1);
	assign hist_waddr = clearing ? clr_q[HIB-1:0] : hidx_s1;
	assign hist_wdata = clearing ? '0 : hist_next;
	assign pat_we     = clearing || (adv && valid_s2);
	assign pat_waddr  = clearing ? clr_q[PIB-1:0] : pidx_s2;
	assign pat_wdata  = clearing ? CtrHalf : ctr_next;

	lhbp_ram #(
		.WIDTH(HB),
		.DEPTH(HisDepth)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (adv),
		.raddr(s_tdata[HIB-1:0]),
		.rdata(hist_rd)
	);

	lhbp_ram #(
		.WIDTH(CB),
		.DEPTH(PatDepth)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(pat_waddr),
		.wdata(pat_wdata),
		.re   (adv),
		.raddr(pidx),
		.rdata(ctr_rd)
	);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= s_tdata[PIB-1:0];
			hidx_s1  <= s_tdata[HIB-1:0];
			taken_s1 <= s_tdata[AddrW];
			hidx_s2  <= hidx_s1;
			hist_s2  <= hist_next;
			pidx_s2  <= pidx;
			taken_s2 <= taken_s1;
			pred_s3  <= pred;
			pidx_s3  <= pidx_s2;
			ctr_s3   <= ctr_next;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = MDataW'(pred_s3);

endmodule

@@ src/lhbp_checker.sv @@
// Port-level checker for the local history branch predictor, bound to the top level.
// Depends on lhbp_pkg for the payload widths.

module lhbp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [lhbp_pkg::MDataW-1:0] m_tdata
);

	import lhbp_pkg::*;

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed or vanished");

	// The padding above the prediction bit is always zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[MDataW-1:1] == '0)
		else $error("output padding bits not zero");

	// Input is only taken when the output register is free to move.
	a_ready_tied: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input accepted while output stalled");

	// If the output is idle and no item was accepted recently enough to be in stage 1 or 2, no result can appear.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && $past(!m_tvalid, 1) && $past(!m_tvalid, 2)
		&& $past(!s_acc, 1) && $past(!s_acc, 2) |=> !m_tvalid)
		else $error("output item without a matching input item");

endmodule

bind local_history_branch_predictor lhbp_checker u_lhbp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ test/tb_local_history_branch_predictor.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the local history branch predictor top level.
// Depends on lhbp_pkg and local_history_branch_predictor; it keeps its own copy of both tables.

module tb_local_history_branch_predictor;

	import lhbp_pkg::*;

	// Table geometry, the same as the defaults of the block.
	localparam int PatBits     = PatternIndexBitsDef;
	localparam int HistBits    = HistoryBitsDef;
	localparam int HistIdxBits = HistoryIndexBitsDef;
	localparam int CtrBits     = CounterBitsDef;
	localparam int PatDepth    = 1 << PatBits;
	localparam int HistDepth   = 1 << HistIdxBits;

	localparam logic [CtrBits-1:0] CtrMax     = '1;
	localparam logic [CtrBits-1:0] CtrWeakNot = CtrBits'((1 << CtrBits) / 2 - 1);

	// The run stops here no matter what. This covers the table sweep after reset,
	// every item with the longest sender gap and the longest receiver stall, and
	// the long hold, several times over.
	localparam int CycleLimit    = 1000000;
	localparam int RandomItems   = 1750;
	localparam int LongHoldLen   = 400;
	localparam int LongHoldAfter = 600;
	localparam int DrainCycles   = 8;

	typedef struct {
		logic [AddrW-1:0] addr;
		logic             taken;
		int               gap;
	} branch_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [SDataW-1:0] s_tdata = '0;  // [31:0] branch_address, [32] taken
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [MDataW-1:0] m_tdata;       // [0] predicted_taken

	// Our own copy of the predictor state.
	logic [CtrBits-1:0]  counter_table [PatDepth];
	logic [HistBits-1:0] history_table [HistDepth];

	branch_item_t pending_branches[$];
	logic         expected_predictions[$];

	int errors = 0;
	int items_queued = 0;
	int branches_accepted = 0;
	int taken_outcomes = 0;
	int mispredictions = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int idle_left = 0;
	int stall_left = 0;
	int hold_cycles = 0;
	logic long_hold = 1'b0;
	logic hold_done = 1'b0;

	local_history_branch_predictor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Returns the prediction the tables give for this branch, then trains them
	// with the actual outcome, just as the block does.
	function automatic logic predict_and_train(input logic [AddrW-1:0] addr,
		input logic outcome);
		logic [HistIdxBits-1:0] hidx;
		logic [HistBits-1:0]    hist;
		logic [PatBits-1:0]     pidx;
		logic [CtrBits-1:0]     ctr;
		logic                   guess;
		hidx = addr[HistIdxBits-1:0];
		hist = history_table[hidx];
		pidx = PatBits'(addr ^ AddrW'(hist));
		ctr = counter_table[pidx];
		guess = (ctr > CtrWeakNot);
		// The counter saturates at both ends.
		if (outcome) begin
			if (ctr != CtrMax)
				ctr = ctr + 1'b1;
		end else if (ctr != '0) begin
			ctr = ctr - 1'b1;
		end
		counter_table[pidx] = ctr;
		// The oldest outcome falls off the top of the history.
		history_table[hidx] = HistBits'({hist, outcome});
		return guess;
	endfunction

	// Idle stretches: mostly short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Queues one branch. Every fourth window of 250 items is sent back to back.
	task automatic push_branch(input logic [AddrW-1:0] addr, input logic taken);
		branch_item_t item;
		item.addr = addr;
		item.taken = taken;
		if ((items_queued / 250) % 4 == 2 || $urandom_range(0, 99) < 50)
			item.gap = 0;
		else
			item.gap = idle_length();
		pending_branches.push_back(item);
		items_queued++;
	endtask

	// Sender: offers the queued items one at a time and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			idle_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				logic guess;
				guess = predict_and_train(s_tdata[AddrW-1:0], s_tdata[AddrW]);
				expected_predictions.push_back(guess);
				branches_accepted++;
				if (s_tdata[AddrW])
					taken_outcomes++;
				if (guess != s_tdata[AddrW])
					mispredictions++;
			end
			// A new item may go out only once the current one, if any, is gone.
			if (!s_tvalid || s_tready) begin
				if (pending_branches.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_left < pending_branches[0].gap) begin
					idle_left <= idle_left + 1;
					s_tvalid <= 1'b0;
				end else begin
					branch_item_t item;
					item = pending_branches.pop_front();
					s_tdata <= {{(SDataW - AddrW - 1){1'b0}}, item.taken, item.addr};
					s_tvalid <= 1'b1;
					idle_left <= 0;
				end
			end
		end
	end

	// Receiver: checks every result against the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_predictions.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual predicted_taken %0b",
						$time, m_tdata[0]);
					errors++;
				end else begin
					logic want;
					want = expected_predictions.pop_front();
					if (m_tdata[0] !== want) begin
						$display("%0t: predicted_taken mismatch, expected %0b, actual %0b",
							$time, want, m_tdata[0]);
						errors++;
					end
				end
				results_seen++;
			end
			// Every fourth window of 300 results runs with no random stalls.
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if ((results_seen / 300) % 4 != 1 && $urandom_range(0, 99) < 25) begin
				stall_left <= idle_length();
				m_tready <= 1'b0;
			end else begin
				m_tready <= !long_hold;
			end
		end
	end

	// One long receiver hold, so the pipeline fills and the block pushes back on
	// the sender, which keeps its items on offer the whole time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_done <= 1'b0;
			hold_cycles <= 0;
		end else if (long_hold) begin
			if (hold_cycles == LongHoldLen - 1) begin
				long_hold <= 1'b0;
				hold_done <= 1'b1;
			end
			hold_cycles <= hold_cycles + 1;
		end else if (!hold_done && results_seen >= LongHoldAfter) begin
			long_hold <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timed out with %0d items unsent and %0d results outstanding",
				$time, pending_branches.size(), expected_predictions.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [AddrW-1:0] base;
		logic [AddrW-1:0] work_set [4];
		logic [5:0]       pattern [4];
		int               period [4];
		int               phase [4];
		int               random_start;
		int               kind;
		int               trip;
		int               reps;
		int               len;
		int               k;

		for (int i = 0; i < PatDepth; i++)
			counter_table[i] = CtrWeakNot;
		for (int i = 0; i < HistDepth; i++)
			history_table[i] = '0;

		// Directed part. Address zero, then the all-ones address taken over and
		// over: its history overflows and its counter sits at the maximum.
		push_branch(32'h0000_0000, 1'b1);
		for (int i = 0; i < 15; i++)
			push_branch(32'hFFFF_FFFF, 1'b1);
		// A fresh entry with a zero history driven to zero and held there.
		for (int i = 0; i < 3; i++)
			push_branch(32'h0000_0002, 1'b0);
		// High address bits differ but the low bits hit the same history entry.
		push_branch(32'h8000_0000, 1'b1);
		push_branch(32'h7FFF_FFC0, 1'b0);
		push_branch(32'hFFFF_F000, 1'b0);

		// Random part: mostly trained behavior (loops and interleaved periodic
		// branches), the rest random noise.
		random_start = items_queued;
		while (items_queued - random_start < RandomItems) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				// A loop branch: taken every trip but the last.
				base = $urandom;
				trip = $urandom_range(2, 12);
				reps = $urandom_range(2, 6);
				for (int r = 0; r < reps; r++)
					for (int i = 0; i < trip; i++)
						push_branch(base, i != trip - 1);
			end else if (kind < 80) begin
				// Four branches with short periodic patterns; the last one aliases
				// the first in the low address bits.
				for (int j = 0; j < 4; j++) begin
					work_set[j] = $urandom;
					pattern[j] = 6'($urandom);
					period[j] = $urandom_range(1, 6);
					phase[j] = 0;
				end
				work_set[3] = work_set[0] ^ (AddrW'($urandom_range(1, 1048575)) << 12);
				len = $urandom_range(20, 40);
				for (int i = 0; i < len; i++) begin
					k = $urandom_range(0, 3);
					push_branch(work_set[k], pattern[k][phase[k] % period[k]]);
					phase[k]++;
				end
			end else begin
				len = $urandom_range(5, 20);
				for (int i = 0; i < len; i++)
					push_branch($urandom, 1'($urandom_range(0, 1)));
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_branches.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_predictions.size() != 0)
			@(posedge clk);
		// Watch a little longer for any stray result.
		repeat (DrainCycles) @(posedge clk);

		$display("Ran %0d branches (%0d taken, %0d mispredicted) over loops, interleaved",
			branches_accepted, taken_outcomes, mispredictions);
		$display("periodic branches, aliased and random addresses, with one long output hold.");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
